### src/pmt_pkg.sv
`default_nettype none

package pmt_pkg;

  // Channel geometry
  localparam int unsigned MAX_CHANNELS     = 4;
  localparam int unsigned BITS_PER_CHANNEL = 3;
  localparam int unsigned CTRL_WIDTH       = MAX_CHANNELS * BITS_PER_CHANNEL;
  localparam int unsigned COUNT_WIDTH      = 32;

  // Bit positions inside one channel's control field
  localparam int unsigned CTRL_IRQ_BIT   = 0;
  localparam int unsigned CTRL_RESET_BIT = 1;
  localparam int unsigned CTRL_STOP_BIT  = 2;

  // Configuration register index
  localparam int unsigned CFG_IDX_WIDTH = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_PRESCALE_LIMIT = 3'd0,
    REG_MATCH_VALUE_0  = 3'd1,
    REG_MATCH_VALUE_1  = 3'd2,
    REG_MATCH_VALUE_2  = 3'd3,
    REG_MATCH_VALUE_3  = 3'd4,
    REG_MATCH_CONTROL  = 3'd5
  } pmt_reg_e;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_CTRL   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_STATUS = 2'd3
  } pmt_op_e;

  typedef struct packed {
    pmt_op_e                 op;
    logic                    ctrl_enable;
    logic                    ctrl_reset;
    logic [MAX_CHANNELS-1:0] clear_mask;
  } pmt_in_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0]  count_now;
    logic [COUNT_WIDTH-1:0]  prescale_now;
    logic [MAX_CHANNELS-1:0] match_flags;
    logic                    irq_out;
    logic                    running;
  } pmt_out_t;

  // Configuration register file contents, seen by the counter core
  typedef struct packed {
    logic [COUNT_WIDTH-1:0]                   prescale_limit;
    logic [MAX_CHANNELS-1:0][COUNT_WIDTH-1:0] match_value;
    logic [CTRL_WIDTH-1:0]                    match_control;
  } pmt_cfg_t;

endpackage

`default_nettype wire

### src/pmt_cfg.sv
`default_nettype none

module pmt_cfg
  import pmt_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  wire logic [COUNT_WIDTH-1:0]   cfg_wdata_i,
  output pmt_cfg_t                      cfg_o,
  output logic                          prescale_clear_o
);

  pmt_cfg_t cfg_q, cfg_d;

  // Register decode; unused indices are dropped
  always_comb begin
    cfg_d            = cfg_q;
    prescale_clear_o = 1'b0;
    if (cfg_we_i) begin
      case (pmt_reg_e'(cfg_idx_i))
        REG_PRESCALE_LIMIT: begin
          cfg_d.prescale_limit = cfg_wdata_i;
          prescale_clear_o     = 1'b1;
        end
        REG_MATCH_VALUE_0: cfg_d.match_value[0] = cfg_wdata_i;
        REG_MATCH_VALUE_1: cfg_d.match_value[1] = cfg_wdata_i;
        REG_MATCH_VALUE_2: cfg_d.match_value[2] = cfg_wdata_i;
        REG_MATCH_VALUE_3: cfg_d.match_value[3] = cfg_wdata_i;
        REG_MATCH_CONTROL: cfg_d.match_control = cfg_wdata_i[CTRL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### src/pmt_core.sv
`default_nettype none

module pmt_core
  import pmt_pkg::*;
#(
  parameter int unsigned MatchChannels = MAX_CHANNELS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     accept_i,
  input  wire pmt_in_t  in_data_i,
  input  wire pmt_cfg_t cfg_i,
  input  wire logic     prescale_clear_i,
  output pmt_out_t      result_o
);

  logic [COUNT_WIDTH-1:0]  count_q, count_d;
  logic [COUNT_WIDTH-1:0]  prescale_q, prescale_d;
  logic                    enable_q, enable_d;
  logic                    hold_q, hold_d;
  logic [MAX_CHANNELS-1:0] pending_q, pending_d;
  logic                    zero_it;

  // Reset-on-match is tested against the count before the advance
  always_comb begin
    zero_it = 1'b0;
    for (int c = 0; c < MatchChannels; c++) begin
      if (cfg_i.match_control[BITS_PER_CHANNEL*c + CTRL_RESET_BIT] &&
          count_q == cfg_i.match_value[c]) begin
        zero_it = 1'b1;
      end
    end
  end

  // Next state for one beat
  always_comb begin
    count_d    = count_q;
    prescale_d = prescale_q;
    enable_d   = enable_q;
    hold_d     = hold_q;
    pending_d  = pending_q;
    if (accept_i) begin
      case (in_data_i.op)
        OP_TICK: begin
          if (hold_q) begin
            count_d    = '0;
            prescale_d = '0;
          end else if (enable_q) begin
            if (prescale_q < cfg_i.prescale_limit) begin
              prescale_d = prescale_q + 1'b1;
            end else begin
              prescale_d = '0;
              count_d    = zero_it ? '0 : count_q + 1'b1;
              // interrupt and stop act on the new count
              for (int c = 0; c < MatchChannels; c++) begin
                if (count_d == cfg_i.match_value[c]) begin
                  if (cfg_i.match_control[BITS_PER_CHANNEL*c + CTRL_IRQ_BIT]) begin
                    pending_d[c] = 1'b1;
                  end
                  if (cfg_i.match_control[BITS_PER_CHANNEL*c + CTRL_STOP_BIT]) begin
                    enable_d = 1'b0;
                  end
                end
              end
            end
          end
        end
        OP_CTRL: begin
          enable_d = in_data_i.ctrl_enable;
          hold_d   = in_data_i.ctrl_reset;
          if (in_data_i.ctrl_reset) begin
            count_d    = '0;
            prescale_d = '0;
          end
        end
        OP_CLEAR: begin
          pending_d = pending_q & ~in_data_i.clear_mask;
        end
        default: ;
      endcase
    end else if (prescale_clear_i) begin
      prescale_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      prescale_q <= '0;
      enable_q   <= 1'b0;
      hold_q     <= 1'b0;
      pending_q  <= '0;
    end else begin
      count_q    <= count_d;
      prescale_q <= prescale_d;
      enable_q   <= enable_d;
      hold_q     <= hold_d;
      pending_q  <= pending_d;
    end
  end

  // Status after this beat
  always_comb begin
    result_o.count_now    = count_d;
    result_o.prescale_now = prescale_d;
    result_o.match_flags  = pending_d;
    result_o.irq_out      = |pending_d;
    result_o.running      = enable_d;
  end

endmodule

`default_nettype wire

### src/pmt_out_stage.sv
`default_nettype none

module pmt_out_stage
  import pmt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire pmt_out_t data_i,
  output logic          stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output pmt_out_t      out_data_o
);

  logic     valid_q, valid_d;
  pmt_out_t data_q;

  // Upstream waits only while a held beat is blocked downstream
  assign stall_o = valid_q & out_stall_i;
  assign valid_d = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

### src/prescaled_match_timer_top.sv
`default_nettype none

// Prescaled 32-bit match timer. Each input beat (tick, control write, flag clear
// or status read) updates the timer state in the cycle it is accepted and yields
// exactly one status beat, presented from the output register on the next cycle.
// One beat is accepted per cycle; the only throttle is the single output
// register, so in_stall_o rises only while a held result is stalled downstream.
// Configuration writes take effect at the next clock edge and are meant to be
// done while no beat is in flight; writing the prescale limit also zeroes the
// prescale counter.
module prescaled_match_timer_top
  import pmt_pkg::*;
#(
  parameter int unsigned MatchChannels = MAX_CHANNELS
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire pmt_in_t                  in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output pmt_out_t                      out_data_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  wire logic [COUNT_WIDTH-1:0]   cfg_wdata_i
);

  pmt_cfg_t cfg;
  pmt_out_t result;
  logic     prescale_clear;
  logic     accept;

  assign accept = in_valid_i & ~in_stall_o;

  pmt_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cfg_o            (cfg),
    .prescale_clear_o (prescale_clear)
  );

  pmt_core #(
    .MatchChannels (MatchChannels)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .in_data_i        (in_data_i),
    .cfg_i            (cfg),
    .prescale_clear_i (prescale_clear),
    .result_o         (result)
  );

  pmt_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .data_i      (result),
    .stall_o     (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### test/pmt_checker.sv
`timescale 1ns / 100ps

// Watches the input, output and register ports of the match timer, keeps its own
// copy of the timer state and flags every status beat that differs from it.
module pmt_checker
  import pmt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  pmt_in_t                  in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  pmt_out_t                 out_data_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_idx_i,
  input  logic [COUNT_WIDTH-1:0]   cfg_wdata_i,
  output int                       mismatches_o,
  output int                       outstanding_o
);

  // Register copy
  logic [COUNT_WIDTH-1:0]  limit_reg;
  logic [COUNT_WIDTH-1:0]  match_reg [MAX_CHANNELS];
  logic [CTRL_WIDTH-1:0]   ctl_reg;

  // Timer state copy
  logic [COUNT_WIDTH-1:0]  main_cnt;
  logic [COUNT_WIDTH-1:0]  pre_cnt;
  logic                    run_en;
  logic                    hold_zero;
  logic [MAX_CHANNELS-1:0] irq_flags;

  // Status beats still owed by the block, oldest first
  pmt_out_t status_due_q [$];

  function automatic logic chan_bit(input int c, input int unsigned pos);
    return ctl_reg[c * BITS_PER_CHANNEL + pos];
  endfunction

  // One tick: prescaler first, main count on its wrap, then match actions
  task automatic timer_tick();
    logic wrap_zero;
    wrap_zero = 1'b0;
    if (hold_zero) begin
      main_cnt = '0;
      pre_cnt  = '0;
    end else if (run_en) begin
      if (pre_cnt < limit_reg) begin
        pre_cnt = pre_cnt + 1'b1;
      end else begin
        pre_cnt = '0;
        // reset bits look at the count before the step
        for (int c = 0; c < MAX_CHANNELS; c++)
          if (chan_bit(c, CTRL_RESET_BIT) && main_cnt == match_reg[c]) wrap_zero = 1'b1;
        main_cnt = wrap_zero ? '0 : main_cnt + 1'b1;
        // interrupt and stop bits look at the new count
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          if (main_cnt == match_reg[c]) begin
            if (chan_bit(c, CTRL_IRQ_BIT)) irq_flags[c] = 1'b1;
            if (chan_bit(c, CTRL_STOP_BIT)) run_en = 1'b0;
          end
        end
      end
    end
  endtask

  task automatic apply_beat(input pmt_in_t beat);
    pmt_out_t st;
    case (beat.op)
      OP_TICK: timer_tick();
      OP_CTRL: begin
        run_en    = beat.ctrl_enable;
        hold_zero = beat.ctrl_reset;
        if (beat.ctrl_reset) begin
          main_cnt = '0;
          pre_cnt  = '0;
        end
      end
      OP_CLEAR: irq_flags = irq_flags & ~beat.clear_mask;
      default: ;
    endcase
    st.count_now    = main_cnt;
    st.prescale_now = pre_cnt;
    st.match_flags  = irq_flags;
    st.irq_out      = |irq_flags;
    st.running      = run_en;
    status_due_q.push_back(st);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [COUNT_WIDTH-1:0] data);
    case (idx)
      REG_PRESCALE_LIMIT: begin
        limit_reg = data;
        pre_cnt   = '0;
      end
      REG_MATCH_VALUE_0: match_reg[0] = data;
      REG_MATCH_VALUE_1: match_reg[1] = data;
      REG_MATCH_VALUE_2: match_reg[2] = data;
      REG_MATCH_VALUE_3: match_reg[3] = data;
      REG_MATCH_CONTROL: ctl_reg = data[CTRL_WIDTH-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [COUNT_WIDTH-1:0] want,
                             input logic [COUNT_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches_o++;
    end
  endtask

  // Compare outgoing beat, then take register writes and incoming beats
  always @(posedge clk_i or negedge rst_ni) begin
    pmt_out_t want;
    if (!rst_ni) begin
      limit_reg = '0;
      for (int c = 0; c < MAX_CHANNELS; c++) match_reg[c] = '0;
      ctl_reg       = '0;
      main_cnt      = '0;
      pre_cnt       = '0;
      run_en        = 1'b0;
      hold_zero     = 1'b0;
      irq_flags     = '0;
      status_due_q.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (status_due_q.size() == 0) begin
          $display("%0t: status beat expected none actual %h", $time, out_data_i);
          mismatches_o++;
        end else begin
          want = status_due_q.pop_front();
          check_field("count_now", want.count_now, out_data_i.count_now);
          check_field("prescale_now", want.prescale_now, out_data_i.prescale_now);
          check_field("match_flags", COUNT_WIDTH'(want.match_flags),
                      COUNT_WIDTH'(out_data_i.match_flags));
          check_field("irq_out", COUNT_WIDTH'(want.irq_out), COUNT_WIDTH'(out_data_i.irq_out));
          check_field("running", COUNT_WIDTH'(want.running), COUNT_WIDTH'(out_data_i.running));
        end
      end
      if (cfg_we_i) write_reg(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_i) apply_beat(in_data_i);
      outstanding_o = status_due_q.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pmt_pkg::*;

  localparam int                       PHASES    = 10;
  localparam int                       PHASE_LEN = 100;
  localparam int                       LONG_HOLD = 60;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPARE = 3'd7;  // unmapped index

  // Per-channel control codes
  localparam logic [2:0] CTL_IRQ   = 3'(1 << CTRL_IRQ_BIT);
  localparam logic [2:0] CTL_RESET = 3'(1 << CTRL_RESET_BIT);
  localparam logic [2:0] CTL_STOP  = 3'(1 << CTRL_STOP_BIT);

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  pmt_in_t                  in_data    = '0;
  logic                     out_stall  = 1'b0;
  logic                     cfg_we     = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx    = '0;
  logic [COUNT_WIDTH-1:0]   cfg_wdata  = '0;
  logic                     in_stall;
  logic                     out_valid;
  pmt_out_t                 out_data;
  int                       mismatches;
  int                       outstanding;

  logic rand_traffic = 1'b0;
  logic held_long    = 1'b0;
  int   tx_quiet     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  prescaled_match_timer_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  pmt_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  function automatic pmt_in_t mk_beat(input pmt_op_e op, input logic en, input logic rst,
                                      input logic [MAX_CHANNELS-1:0] mask);
    pmt_in_t b;
    b.op          = op;
    b.ctrl_enable = en;
    b.ctrl_reset  = rst;
    b.clear_mask  = mask;
    return b;
  endfunction

  function automatic logic [CTRL_WIDTH-1:0] chan_ctl(input int c, input logic [2:0] bits);
    return CTRL_WIDTH'(bits) << (c * BITS_PER_CHANNEL);
  endfunction

  // Sender gaps: mostly none or short, a few long, with runs of back-to-back beats
  function automatic int tx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_quiet > 0) begin
      tx_quiet--;
      return 0;
    end
    if (r < 3) tx_quiet = $urandom_range(20, 50);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  task automatic send_beat(input pmt_in_t b);
    int gap;
    gap = tx_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait for every status beat to come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                         input logic [COUNT_WIDTH-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
  endtask

  task automatic program_timer(input logic [COUNT_WIDTH-1:0] limit,
                               input logic [COUNT_WIDTH-1:0] m0, m1, m2, m3,
                               input logic [CTRL_WIDTH-1:0] ctl);
    drain();
    put_reg(REG_PRESCALE_LIMIT, limit);
    put_reg(REG_MATCH_VALUE_0, m0);
    put_reg(REG_MATCH_VALUE_1, m1);
    put_reg(REG_MATCH_VALUE_2, m2);
    put_reg(REG_MATCH_VALUE_3, m3);
    put_reg(REG_MATCH_CONTROL, COUNT_WIDTH'(ctl));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [COUNT_WIDTH-1:0] rnd_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return '0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] rnd_match();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 30);
    if (r < 95) return $urandom;
    return '1;
  endfunction

  // Mostly ticks so the count reaches the compare values; unused fields random
  function automatic pmt_in_t rnd_beat();
    pmt_in_t b;
    int r;
    b = mk_beat(OP_STATUS, 1'($urandom), 1'($urandom), 4'($urandom));
    r = $urandom_range(0, 99);
    if (r < 70) begin
      b.op = OP_TICK;
    end else if (r < 80) begin
      b.op          = OP_CTRL;
      b.ctrl_enable = ($urandom_range(0, 9) != 0);
      b.ctrl_reset  = ($urandom_range(0, 5) == 0);
    end else if (r < 90) begin
      b.op = OP_CLEAR;
    end
    return b;
  endfunction

  // Receiver: one long hold-off once random traffic starts, then random stalls
  initial begin : receiver
    int r;
    forever begin
      @(negedge clk);
      if (rand_traffic && !held_long) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r >= 97) begin
          out_stall <= 1'b0;
          repeat ($urandom_range(30, 60)) @(negedge clk);
        end else if (r < 65) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          repeat ((r < 92) ? $urandom_range(0, 2) : $urandom_range(5, 25)) @(negedge clk);
        end
      end
    end
  end

  initial begin : limit_guard
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset configuration: disabled tick, free count, hold, release
    send_beat(mk_beat(OP_STATUS, 1'b1, 1'b1, 4'hf));
    send_beat(mk_beat(OP_TICK, 1'b1, 1'b1, 4'hf));
    send_beat(mk_beat(OP_CTRL, 1'b1, 1'b0, 4'h0));
    send_beat(mk_beat(OP_TICK, 1'b0, 1'b0, 4'h0));
    send_beat(mk_beat(OP_TICK, 1'b0, 1'b0, 4'h0));
    send_beat(mk_beat(OP_CLEAR, 1'b0, 1'b0, 4'hf));
    send_beat(mk_beat(OP_CTRL, 1'b1, 1'b1, 4'h0));
    send_beat(mk_beat(OP_TICK, 1'b0, 1'b0, 4'h0));
    send_beat(mk_beat(OP_CTRL, 1'b0, 1'b0, 4'h0));

    // Reset and stop on the same count, an unmapped index written once
    program_timer(32'd1, 32'd1, 32'd3, 32'd3, '1,
                  chan_ctl(0, CTL_IRQ) | chan_ctl(1, CTL_IRQ | CTL_RESET) |
                  chan_ctl(2, CTL_IRQ | CTL_STOP) | chan_ctl(3, CTL_IRQ | CTL_RESET | CTL_STOP));
    put_reg(REG_SPARE, '1);
    @(negedge clk);
    cfg_we <= 1'b0;
    send_beat(mk_beat(OP_CTRL, 1'b1, 1'b0, 4'h0));
    repeat (7) send_beat(mk_beat(OP_TICK, 1'b0, 1'b0, 4'h0));
    send_beat(mk_beat(OP_STATUS, 1'b0, 1'b0, 4'h0));
    send_beat(mk_beat(OP_CLEAR, 1'b0, 1'b0, 4'h5));
    send_beat(mk_beat(OP_CTRL, 1'b1, 1'b0, 4'h0));
    repeat (3) send_beat(mk_beat(OP_TICK, 1'b0, 1'b0, 4'h0));
    send_beat(mk_beat(OP_CLEAR, 1'b0, 1'b0, 4'hf));

    // Random phases, the first two at the register extremes
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0)
        program_timer('1, '1, '1, '1, '1, '1);
      else if (p == 1)
        program_timer('0, '0, '0, '0, '0, '1);
      else
        program_timer(rnd_limit(), rnd_match(), rnd_match(), rnd_match(), rnd_match(),
                      CTRL_WIDTH'($urandom));
      send_beat(mk_beat(OP_CTRL, 1'b1, 1'b1, 4'($urandom)));
      send_beat(mk_beat(OP_CTRL, 1'b1, 1'b0, 4'($urandom)));
      // long receiver hold-off lands while beats keep coming
      rand_traffic = 1'b1;
      repeat (PHASE_LEN - 2) send_beat(rnd_beat());
    end

    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
